FILE: rtl/sbi_pkg.sv
// Package with the shared types and constants of the segment and box intersection block.
package sbi_pkg;

    localparam int AXES    = 3;
    localparam int FIX_W   = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef logic signed [FIX_W-1:0] fix_t;

    typedef enum logic [2:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } reg_idx_t;

    typedef struct packed {
        fix_t start_x;
        fix_t start_y;
        fix_t start_z;
        fix_t end_x;
        fix_t end_y;
        fix_t end_z;
    } seg_t;

    typedef struct packed {
        logic hit;
        fix_t hit_x;
        fix_t hit_y;
        fix_t hit_z;
    } res_t;

    typedef struct packed {
        logic                                enclosed;
        logic [AXES-1:0]                     skip;
        logic [AXES-1:0]                     neg;
        logic [AXES-1:0]                     big;
        logic [AXES-1:0][FIX_W-1:0]          s;
        logic [AXES-1:0][FIX_W:0]            d;
        logic [AXES-1:0][FIX_W:0]            dmag;
        logic [AXES-1:0][FIX_W-1:0]          plane;
    } carry_t;

endpackage

FILE: rtl/segment_box_intersection.sv
// Top level of the segment and box intersection pipeline with its register port.
//
// The block takes one segment transaction per cycle and returns one result transaction for each,
// in order, after the capture, set-up, division, selection, product and output registers. The
// division resolves one quotient bit per pipeline stage for all three axes in parallel;
// a stall on the result side holds the whole pipeline. The user must write the box corners through
// the register port while no transaction is in flight; the block itself does not enforce this.
module segment_box_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbi_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbi_pkg::DATA_W-1:0]   pwdata,
    output logic [sbi_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         seg_valid,
    output logic                         seg_ready,
    input  sbi_pkg::seg_t                seg,
    output logic                         res_valid,
    input  logic                         res_ready,
    output sbi_pkg::res_t                res
);

    localparam int QW   = FRAC_BITS + 1;
    localparam int RW   = sbi_pkg::FIX_W + 2;
    localparam int DW   = sbi_pkg::FIX_W + 1;
    localparam int PW   = QW + 1 + DW;
    localparam int SW   = sbi_pkg::FIX_W + 2;
    localparam int NA   = sbi_pkg::AXES;
    localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [NA-1:0][sbi_pkg::FIX_W-1:0] box_min_reg;
    logic [NA-1:0][sbi_pkg::FIX_W-1:0] box_max_reg;
    logic                              wr_en;
    logic                              adv;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= '0;
            box_max_reg <= '0;
        end
        else if (wr_en)
        begin
            case (sbi_pkg::reg_idx_t'(paddr[4:2]))
                sbi_pkg::REG_BOX_MIN_X: box_min_reg[0] <= pwdata;
                sbi_pkg::REG_BOX_MIN_Y: box_min_reg[1] <= pwdata;
                sbi_pkg::REG_BOX_MIN_Z: box_min_reg[2] <= pwdata;
                sbi_pkg::REG_BOX_MAX_X: box_max_reg[0] <= pwdata;
                sbi_pkg::REG_BOX_MAX_Y: box_max_reg[1] <= pwdata;
                sbi_pkg::REG_BOX_MAX_Z: box_max_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sbi_pkg::reg_idx_t'(paddr[4:2]))
            sbi_pkg::REG_BOX_MIN_X: prdata = box_min_reg[0];
            sbi_pkg::REG_BOX_MIN_Y: prdata = box_min_reg[1];
            sbi_pkg::REG_BOX_MIN_Z: prdata = box_min_reg[2];
            sbi_pkg::REG_BOX_MAX_X: prdata = box_max_reg[0];
            sbi_pkg::REG_BOX_MAX_Y: prdata = box_max_reg[1];
            sbi_pkg::REG_BOX_MAX_Z: prdata = box_max_reg[2];
            default:                prdata = '0;
        endcase
    end

    // Stage one: capture the segment and classify the start on each axis.
    logic                              v1_reg;
    logic [NA-1:0][sbi_pkg::FIX_W-1:0] s1_reg;
    logic [NA-1:0][sbi_pkg::FIX_W-1:0] e1_reg;
    logic [NA-1:0]                     below1_reg;
    logic [NA-1:0]                     above1_reg;
    logic [NA-1:0][sbi_pkg::FIX_W-1:0] s_in;
    logic [NA-1:0][sbi_pkg::FIX_W-1:0] e_in;
    logic [NA-1:0]                     below_in;
    logic [NA-1:0]                     above_in;

    assign seg_ready = adv;
    assign s_in = {seg.start_z, seg.start_y, seg.start_x};
    assign e_in = {seg.end_z, seg.end_y, seg.end_x};

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            below_in[i] = $signed(s_in[i]) < $signed(box_min_reg[i]);
            above_in[i] = !below_in[i] && ($signed(s_in[i]) > $signed(box_max_reg[i]));
        end
    end

    // Stage two: direction, plane distance, magnitudes and the division set-up.
    logic                   v2_in;
    sbi_pkg::carry_t        c2_in;
    logic [NA-1:0][RW-1:0]  r2_in;
    logic [NA-1:0][DW-1:0]  num_w;
    logic [NA-1:0][DW-1:0]  nmag_w;

    assign v2_in = v1_reg;

    always_comb
    begin
        c2_in = '0;
        for (int i = 0; i < NA; i++)
        begin
            c2_in.s[i]     = s1_reg[i];
            c2_in.d[i]     = DW'($signed(e1_reg[i])) - DW'($signed(s1_reg[i]));
            c2_in.plane[i] = below1_reg[i] ? box_min_reg[i] : box_max_reg[i];
            num_w[i]       = DW'($signed(c2_in.plane[i])) - DW'($signed(s1_reg[i]));
            nmag_w[i]      = num_w[i][DW-1] ? (~num_w[i] + 1'b1) : num_w[i];
            c2_in.dmag[i]  = c2_in.d[i][DW-1] ? (~c2_in.d[i] + 1'b1) : c2_in.d[i];
            c2_in.neg[i]   = num_w[i][DW-1] ^ c2_in.d[i][DW-1];
            c2_in.skip[i]  = !(below1_reg[i] || above1_reg[i]) || (c2_in.d[i] == '0);
            c2_in.big[i]   = {1'b0, nmag_w[i]} >= {c2_in.dmag[i], 1'b0};
            r2_in[i]       = c2_in.big[i] ? '0 : {1'b0, nmag_w[i]};
        end
        c2_in.enclosed = !(|below1_reg) && !(|above1_reg);
    end

    // Division stages: index 0 holds the set-up, each later stage resolves one quotient bit.
    logic                  dv_reg  [0:QW];
    sbi_pkg::carry_t       dc_reg  [0:QW];
    logic [NA-1:0][RW-1:0] rem_reg [0:QW];
    logic [NA-1:0][QW-1:0] quo_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= seg_valid;
            dv_reg[0] <= v2_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg      <= s_in;
            e1_reg      <= e_in;
            below1_reg  <= below_in;
            above1_reg  <= above_in;
            dc_reg[0]   <= c2_in;
            rem_reg[0]  <= r2_in;
            quo_reg[0]  <= '0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_div
            logic [NA-1:0][RW-1:0] rem_next;
            logic [NA-1:0][QW-1:0] quo_next;
            logic [NA-1:0][RW-1:0] diff;

            always_comb
            begin
                for (int i = 0; i < NA; i++)
                begin
                    diff[i] = rem_reg[k-1][i] - {1'b0, dc_reg[k-1].dmag[i]};
                    if (rem_reg[k-1][i] >= {1'b0, dc_reg[k-1].dmag[i]})
                    begin
                        rem_next[i] = {diff[i][RW-2:0], 1'b0};
                        quo_next[i] = {quo_reg[k-1][i][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = {rem_reg[k-1][i][RW-2:0], 1'b0};
                        quo_next[i] = {quo_reg[k-1][i][QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_reg[k] <= dv_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dc_reg[k]  <= dc_reg[k-1];
                    rem_reg[k] <= rem_next;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    // Selection stage: classify each plane parameter and pick the entry plane.
    logic            vm_reg;
    sbi_pkg::carry_t cm_reg;
    logic            miss_m_reg;
    logic [1:0]      best_m_reg;
    logic [QW-1:0]   t_m_reg;
    logic [NA-1:0]   ok_w;
    logic [NA-1:0]   over_w;
    logic [NA-1:0][QW-1:0] tv_w;
    logic            bv_w;
    logic [1:0]      bi_w;
    logic [QW-1:0]   bt_w;
    sbi_pkg::carry_t cq;

    assign cq = dc_reg[QW];

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            tv_w[i]   = cq.neg[i] ? '0 : quo_reg[QW][i];
            over_w[i] = !cq.skip[i] && !cq.neg[i] && (cq.big[i] || quo_reg[QW][i] > ONE);
            ok_w[i]   = !cq.skip[i] && !over_w[i]
                        && !(cq.neg[i] && (cq.big[i] || quo_reg[QW][i] != '0));
        end
        bv_w = ok_w[0];
        bi_w = 2'd0;
        bt_w = tv_w[0];
        for (int i = 1; i < NA; i++)
        begin
            if (ok_w[i] && (!bv_w || bt_w < tv_w[i]))
            begin
                bv_w = 1'b1;
                bi_w = 2'(i);
                bt_w = tv_w[i];
            end
        end
    end

    // Product stage and output stage.
    logic                         vp_reg;
    sbi_pkg::carry_t              cp_reg;
    logic                         miss_p_reg;
    logic [1:0]                   best_p_reg;
    logic [NA-1:0][PW-1:0]        prod_reg;
    logic [NA-1:0][PW-1:0]        prod_w;
    logic [NA-1:0][SW-1:0]        p_w;
    logic [NA-1:0]                out_w;
    sbi_pkg::res_t                res_w;
    logic                         res_valid_reg;
    sbi_pkg::res_t                res_reg;

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            prod_w[i] = PW'($signed({1'b0, t_m_reg})) * PW'($signed(cm_reg.d[i]));
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (best_p_reg == 2'(i))
            begin
                p_w[i]   = SW'($signed(cp_reg.plane[i]));
                out_w[i] = 1'b0;
            end
            else
            begin
                p_w[i]   = SW'($signed(cp_reg.s[i]))
                           + SW'($signed(prod_reg[i][PW-1:FRAC_BITS]));
                out_w[i] = ($signed(p_w[i]) < $signed(SW'($signed(box_min_reg[i]))))
                           || ($signed(p_w[i]) > $signed(SW'($signed(box_max_reg[i]))));
            end
        end
        res_w = '0;
        if (cp_reg.enclosed)
        begin
            res_w.hit   = 1'b1;
            res_w.hit_x = cp_reg.s[0];
            res_w.hit_y = cp_reg.s[1];
            res_w.hit_z = cp_reg.s[2];
        end
        else if (!miss_p_reg && !(|out_w))
        begin
            res_w.hit   = 1'b1;
            res_w.hit_x = p_w[0][sbi_pkg::FIX_W-1:0];
            res_w.hit_y = p_w[1][sbi_pkg::FIX_W-1:0];
            res_w.hit_z = p_w[2][sbi_pkg::FIX_W-1:0];
        end
    end

    assign adv       = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg        <= 1'b0;
            vp_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vm_reg        <= dv_reg[QW];
            vp_reg        <= vm_reg;
            res_valid_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cm_reg     <= cq;
            miss_m_reg <= !bv_w || (|over_w);
            best_m_reg <= bi_w;
            t_m_reg    <= bt_w;
            cp_reg     <= cm_reg;
            miss_p_reg <= miss_m_reg;
            best_p_reg <= best_m_reg;
            prod_reg   <= prod_w;
            res_reg    <= res_w;
        end
    end

endmodule
